### hdl/segmented_stream_statistics_assert.svh
`ifndef SEGMENTED_STREAM_STATISTICS_ASSERT_SVH
`define SEGMENTED_STREAM_STATISTICS_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segmented_stream_statistics: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segmented_stream_statistics: next-cycle check failed");

`endif

### hdl/sss_pkg.sv
`default_nettype none

package sss_pkg;

  // Field widths.
  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int SUM_BITS     = 32;
  localparam int VALUE_BITS   = SAMPLE_BITS - 1;
  localparam int MEAN_BITS    = VALUE_BITS + FRAC_BITS;

  // Divider widths: the scaled sum and the part of it above the quotient bits.
  localparam int DVD_BITS     = SUM_BITS + FRAC_BITS;
  localparam int HI_BITS      = DVD_BITS - MEAN_BITS;
  localparam int CMP_BITS     = HI_BITS + COUNT_BITS;
  localparam int DIV_CNT_BITS = $clog2(MEAN_BITS);

  // Report kinds.
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_BATCH   = 1'b1;

  // One result beat.
  typedef struct packed {
    logic                  report_kind;
    logic [COUNT_BITS-1:0] segment_number;
    logic [COUNT_BITS-1:0] sample_count;
    logic                  segment_empty;
    logic [MEAN_BITS-1:0]  mean_q8;
    logic [VALUE_BITS-1:0] segment_min;
    logic                  batch_empty;
    logic [VALUE_BITS-1:0] max_value;
    logic [COUNT_BITS-1:0] max_segment;
    logic [COUNT_BITS-1:0] max_position;
    logic                  last;
  } report_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic upd;
    logic div_start;
    logic div_step;
    logic load_seg;
    logic batch;
    logic load_batch;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic smp_pos;
    logic smp_neg;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/sss_if.sv
`default_nettype none

// Sample channel.
interface sss_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sss_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Report channel.
interface sss_out_if;
  logic                                valid;
  logic                                ready;
  logic                                report_kind;
  logic [sss_pkg::COUNT_BITS-1:0]      segment_number;
  logic [sss_pkg::COUNT_BITS-1:0]      sample_count;
  logic                                segment_empty;
  logic [sss_pkg::MEAN_BITS-1:0]       mean_q8;
  logic [sss_pkg::VALUE_BITS-1:0]      segment_min;
  logic                                batch_empty;
  logic [sss_pkg::VALUE_BITS-1:0]      max_value;
  logic [sss_pkg::COUNT_BITS-1:0]      max_segment;
  logic [sss_pkg::COUNT_BITS-1:0]      max_position;
  logic                                last;

  modport source (
    output valid, output report_kind, output segment_number, output sample_count,
    output segment_empty, output mean_q8, output segment_min, output batch_empty,
    output max_value, output max_segment, output max_position, output last,
    input ready
  );
  modport sink (
    input valid, input report_kind, input segment_number, input sample_count,
    input segment_empty, input mean_q8, input segment_min, input batch_empty,
    input max_value, input max_segment, input max_position, input last,
    output ready
  );
endinterface

`default_nettype wire

### hdl/segmented_stream_statistics.sv
// A positive sample is taken in ST_IDLE, which it does not leave, and gives no report.
// A zero or negative sample closes its segment: the bit-serial mean divider steps through
// each quotient bit in ST_DIV; ST_WAIT loads its report; intake resumes back in ST_IDLE.
// A negative sample's batch report is offered in the cycle after its segment report is taken.
// A stalled report channel keeps the block in ST_WAIT, holding off intake.
// Reset (rst_ni low, asynchronous) starts an empty batch at segment 1 with no report pending.
`default_nettype none

module segmented_stream_statistics (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sss_in_if.sink     in_i,
  sss_out_if.source  out_o
);
  import sss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  report_t    report;
  logic       in_ready;
  logic       out_valid;

  sss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sss_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (in_i.sample),
    .cmd_i    (cmd),
    .status_o (status),
    .report_o (report)
  );

  // Channel wiring.
  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid;
  assign out_o.report_kind    = report.report_kind;
  assign out_o.segment_number = report.segment_number;
  assign out_o.sample_count   = report.sample_count;
  assign out_o.segment_empty  = report.segment_empty;
  assign out_o.mean_q8        = report.mean_q8;
  assign out_o.segment_min    = report.segment_min;
  assign out_o.batch_empty    = report.batch_empty;
  assign out_o.max_value      = report.max_value;
  assign out_o.max_segment    = report.max_segment;
  assign out_o.max_position   = report.max_position;
  assign out_o.last           = report.last;

endmodule

`default_nettype wire

### hdl/sss_div.sv
`default_nettype none

// Radix-2 restoring divider for the segment mean: one quotient bit per step.
module sss_div (
  input  wire logic                           clk_i,
  input  wire logic                           start_i,
  input  wire logic                           step_i,
  input  wire logic [sss_pkg::SUM_BITS-1:0]   sum_i,
  input  wire logic [sss_pkg::COUNT_BITS-1:0] count_i,
  output logic      [sss_pkg::MEAN_BITS-1:0]  quotient_o,
  output logic                                ovf_o
);
  import sss_pkg::*;

  logic [DVD_BITS-1:0]   dvd;
  logic [HI_BITS-1:0]    hi;
  logic [CMP_BITS-1:0]   hi_x;
  logic [CMP_BITS-1:0]   cnt_x;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [MEAN_BITS-1:0]  quo_q, quo_d;
  logic                  ovf_q, ovf_d;

  // Scaled dividend; the bits above the quotient field seed the remainder.
  assign dvd   = DVD_BITS'(sum_i) << FRAC_BITS;
  assign hi    = dvd[DVD_BITS-1:MEAN_BITS];
  assign hi_x  = CMP_BITS'(hi);
  assign cnt_x = CMP_BITS'(count_i);

  // Trial subtraction of one step.
  assign trial = {rem_q, quo_q[MEAN_BITS-1]};
  assign diff  = trial - {1'b0, count_i};
  assign fits  = trial >= {1'b0, count_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    ovf_d = ovf_q;
    if (start_i) begin
      // A quotient that does not fit the field is clamped at the end.
      rem_d = COUNT_BITS'(hi);
      quo_d = dvd[MEAN_BITS-1:0];
      ovf_d = hi_x >= cnt_x;
    end else if (step_i) begin
      rem_d = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_d = {quo_q[MEAN_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign quotient_o = quo_q;
  assign ovf_o      = ovf_q;

endmodule

`default_nettype wire

### hdl/sss_datapath.sv
`default_nettype none

// Accumulators, batch maximum tracker, mean divider and report registers.
module sss_datapath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic signed [sss_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire sss_pkg::dp_cmd_t                       cmd_i,
  output sss_pkg::dp_status_t                         status_o,
  output sss_pkg::report_t                            report_o
);
  import sss_pkg::*;

  logic [VALUE_BITS-1:0] raw;
  logic [SUM_BITS:0]     sum_add;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  count_sat;
  logic [MEAN_BITS-1:0]  quotient;
  logic                  ovf;
  logic [MEAN_BITS-1:0]  mean;
  report_t               seg_rpt;
  report_t               batch_rpt;

  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [VALUE_BITS-1:0] min_q, min_d;
  logic [COUNT_BITS-1:0] index_q, index_d;
  logic [VALUE_BITS-1:0] bmax_q, bmax_d;
  logic [COUNT_BITS-1:0] mseg_q, mseg_d;
  logic [COUNT_BITS-1:0] mpos_q, mpos_d;
  logic                  seen_q, seen_d;
  report_t               hold_q, hold_d;
  report_t               report_q, report_d;

  // Sample classification.
  assign raw              = sample_i[VALUE_BITS-1:0];
  assign status_o.smp_neg = sample_i[SAMPLE_BITS-1];
  assign status_o.smp_pos = !sample_i[SAMPLE_BITS-1] && (sample_i != '0);

  // Saturating counter and sum.
  assign count_sat = (count_q == '1);
  assign count_inc = count_sat ? count_q : count_q + 1'b1;
  assign sum_add   = (SUM_BITS + 1)'(sum_q) + (SUM_BITS + 1)'(raw);

  sss_div u_div (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .sum_i      (sum_q),
    .count_i    (count_q),
    .quotient_o (quotient),
    .ovf_o      (ovf)
  );

  // Mean with clamping; an empty segment reads zero.
  always_comb begin
    if (count_q == '0) begin
      mean = '0;
    end else if (ovf) begin
      mean = '1;
    end else begin
      mean = quotient;
    end
  end

  // Segment and batch summaries of the current state.
  always_comb begin
    seg_rpt                = '0;
    seg_rpt.report_kind    = KIND_SEGMENT;
    seg_rpt.segment_number = index_q;
    seg_rpt.sample_count   = count_q;
    seg_rpt.segment_empty  = (count_q == '0);
    seg_rpt.mean_q8        = mean;
    seg_rpt.segment_min    = (count_q == '0) ? '0 : min_q;
    seg_rpt.last           = !cmd_i.batch;

    batch_rpt                = '0;
    batch_rpt.report_kind    = KIND_BATCH;
    batch_rpt.segment_number = index_q;
    batch_rpt.batch_empty    = !seen_q;
    batch_rpt.max_value      = seen_q ? bmax_q : '0;
    batch_rpt.max_segment    = seen_q ? mseg_q : '0;
    batch_rpt.max_position   = seen_q ? mpos_q : '0;
    batch_rpt.last           = 1'b1;
  end

  // Next-state of the statistics.
  always_comb begin
    sum_d    = sum_q;
    count_d  = count_q;
    min_d    = min_q;
    index_d  = index_q;
    bmax_d   = bmax_q;
    mseg_d   = mseg_q;
    mpos_d   = mpos_q;
    seen_d   = seen_q;
    hold_d   = hold_q;
    report_d = report_q;

    // A data sample updates the segment and the batch maximum.
    if (cmd_i.upd) begin
      if ((count_q == '0) || (raw < min_q)) begin
        min_d = raw;
      end
      if (!count_sat) begin
        count_d = count_inc;
        sum_d   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
      end
      if (raw > bmax_q) begin
        bmax_d = raw;
        mseg_d = index_q;
        mpos_d = count_inc;
      end
      seen_d = 1'b1;
    end

    // Closing a segment captures its summary and starts the next one.
    if (cmd_i.load_seg) begin
      report_d = seg_rpt;
      sum_d    = '0;
      count_d  = '0;
      min_d    = '0;
      if (cmd_i.batch) begin
        hold_d  = batch_rpt;
        index_d = COUNT_BITS'(1);
        bmax_d  = '0;
        mseg_d  = '0;
        mpos_d  = '0;
        seen_d  = 1'b0;
      end else if (index_q != '1) begin
        index_d = index_q + 1'b1;
      end
    end

    // The batch summary follows once the segment summary is taken.
    if (cmd_i.load_batch) begin
      report_d = hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      min_q   <= '0;
      index_q <= COUNT_BITS'(1);
      bmax_q  <= '0;
      mseg_q  <= '0;
      mpos_q  <= '0;
      seen_q  <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      min_q   <= min_d;
      index_q <= index_d;
      bmax_q  <= bmax_d;
      mseg_q  <= mseg_d;
      mpos_q  <= mpos_d;
      seen_q  <= seen_d;
    end
  end

  // Report payload registers.
  always_ff @(posedge clk_i) begin
    hold_q   <= hold_d;
    report_q <= report_d;
  end

  assign report_o = report_q;

endmodule

`default_nettype wire

### hdl/sss_ctrl.sv
`default_nettype none

// Sequencer: sample intake, divider stepping and report beat flow.
module sss_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire sss_pkg::dp_status_t status_i,
  output sss_pkg::dp_cmd_t         cmd_o
);
  import sss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_WAIT = 3'b100
  } ctrl_state_e;

  localparam logic [DIV_CNT_BITS-1:0] DivLast = DIV_CNT_BITS'(MEAN_BITS - 1);

  ctrl_state_e             state_q, state_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                    batch_q, batch_d;
  logic                    out_valid_q, out_valid_d;
  logic                    pend_q, pend_d;
  logic                    in_acc;
  logic                    out_acc;
  logic                    close;
  logic                    free;

  // Handshake decode.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign close       = in_acc && !status_i.smp_pos;
  assign free        = !pend_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Datapath commands.
  assign cmd_o.upd        = in_acc && status_i.smp_pos;
  assign cmd_o.div_start  = close;
  assign cmd_o.div_step   = (state_q == ST_DIV);
  assign cmd_o.load_seg   = (state_q == ST_WAIT) && free;
  assign cmd_o.batch      = batch_q;
  assign cmd_o.load_batch = out_acc && pend_q;

  // State sequencing.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    batch_d = batch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (close) begin
          state_d = ST_DIV;
          cnt_d   = '0;
          batch_d = status_i.smp_neg;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy and the pending batch summary.
  always_comb begin
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    if (cmd_o.load_seg) begin
      out_valid_d = 1'b1;
      pend_d      = batch_q;
    end else if (cmd_o.load_batch) begin
      pend_d = 1'b0;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      batch_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      batch_q     <= batch_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

endmodule

`default_nettype wire

### hdl/sss_checker.sv
`default_nettype none
`include "segmented_stream_statistics_assert.svh"

// Port-level checks of the statistics block.
module sss_checker (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   in_valid_i,
  input wire logic                                   in_ready_i,
  input wire logic signed [sss_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input wire logic                                   out_valid_i,
  input wire logic                                   out_ready_i,
  input wire logic                                   out_kind_i,
  input wire logic [sss_pkg::COUNT_BITS-1:0]         out_count_i,
  input wire logic                                   out_empty_i,
  input wire logic                                   out_last_i
);
  import sss_pkg::*;

  logic seg_beat;
  logic seg_mid_taken;

  // Segment report beats, and those taken while a batch report is still owed.
  assign seg_beat      = out_valid_i && (out_kind_i == KIND_SEGMENT);
  assign seg_mid_taken = seg_beat && out_ready_i && !out_last_i;

  // A stalled report beat stays offered.
  `SSS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // A batch report always ends the results of its sample.
  `SSS_ASSERT_IMP(a_batch_last, out_valid_i && (out_kind_i == KIND_BATCH), out_last_i)

  // A segment report that is not last is followed at once by the batch report.
  `SSS_ASSERT_NXT(a_batch_follows, seg_mid_taken, out_valid_i && (out_kind_i == KIND_BATCH))

  // The empty flag of a segment report agrees with its count.
  `SSS_ASSERT_IMP(a_seg_empty, seg_beat, out_empty_i == (out_count_i == '0))

  // Intake pauses while a closed segment is summarized.
  `SSS_ASSERT_NXT(a_close_stall, in_valid_i && in_ready_i && (in_sample_i == '0), !in_ready_i)

endmodule

bind segmented_stream_statistics sss_checker u_sss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_sample_i (in_i.sample),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.report_kind),
  .out_count_i (out_o.sample_count),
  .out_empty_i (out_o.segment_empty),
  .out_last_i  (out_o.last)
);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import sss_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
  localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = '1;

  logic clk_i;
  logic rst_ni;

  sss_in_if  in_if ();
  sss_out_if out_if ();

  segmented_stream_statistics dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Reports still owed by the block, oldest first.
  report_t     pending_reports[$];
  int unsigned mismatches;
  int unsigned samples_sent;

  // Knobs shared by the tests and the two channel drivers.
  bit source_gaps;
  bit sink_gaps;
  bit hold_request;

  // Running statistics of the open segment and batch.
  logic [SUM_BITS-1:0]   seg_sum;
  logic [COUNT_BITS-1:0] seg_cnt;
  logic [VALUE_BITS-1:0] seg_min;
  logic [COUNT_BITS-1:0] seg_idx;
  logic [VALUE_BITS-1:0] peak_val;
  logic [COUNT_BITS-1:0] peak_seg;
  logic [COUNT_BITS-1:0] peak_pos;
  bit                    any_positive;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Statistics tracking.
  function automatic void clear_segment();
    seg_sum = '0;
    seg_cnt = '0;
    seg_min = '0;
  endfunction

  function automatic void clear_batch();
    clear_segment();
    seg_idx      = COUNT_BITS'(1);
    peak_val     = '0;
    peak_seg     = '0;
    peak_pos     = '0;
    any_positive = 1'b0;
  endfunction

  function automatic report_t segment_report(input logic is_last);
    report_t                        r;
    logic [SUM_BITS+FRAC_BITS-1:0] scaled;
    logic [SUM_BITS+FRAC_BITS-1:0] quotient;
    r                = '0;
    r.report_kind    = KIND_SEGMENT;
    r.segment_number = seg_idx;
    r.sample_count   = seg_cnt;
    r.segment_empty  = (seg_cnt == 0);
    if (seg_cnt != 0) begin
      scaled        = {seg_sum, {FRAC_BITS{1'b0}}};
      quotient      = scaled / seg_cnt;
      r.mean_q8     = (quotient > MEAN_MAX) ? MEAN_MAX : quotient[MEAN_BITS-1:0];
      r.segment_min = seg_min;
    end
    r.last = is_last;
    return r;
  endfunction

  function automatic report_t batch_report();
    report_t r;
    r                = '0;
    r.report_kind    = KIND_BATCH;
    r.segment_number = seg_idx;
    r.batch_empty    = !any_positive;
    if (any_positive) begin
      r.max_value    = peak_val;
      r.max_segment  = peak_seg;
      r.max_position = peak_pos;
    end
    r.last = 1'b1;
    return r;
  endfunction

  // Folds one accepted sample into the statistics and queues the reports it owes.
  function automatic void track_sample(input logic signed [SAMPLE_BITS-1:0] s);
    logic [SUM_BITS:0]     wide_sum;
    logic [VALUE_BITS-1:0] v;
    v = s[VALUE_BITS-1:0];
    if (s > 0) begin
      if (seg_cnt == 0 || v < seg_min) seg_min = v;
      // A saturated count freezes the sum as well.
      if (seg_cnt != COUNT_MAX) begin
        seg_cnt  = seg_cnt + 1'b1;
        wide_sum = {1'b0, seg_sum} + v;
        seg_sum  = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_BITS-1:0];
      end
      // Only a strictly larger value moves the batch maximum.
      if (v > peak_val) begin
        peak_val = v;
        peak_seg = seg_idx;
        peak_pos = seg_cnt;
      end
      any_positive = 1'b1;
    end else if (s == 0) begin
      pending_reports.push_back(segment_report(1'b1));
      clear_segment();
      if (seg_idx != COUNT_MAX) seg_idx = seg_idx + 1'b1;
    end else begin
      pending_reports.push_back(segment_report(1'b0));
      pending_reports.push_back(batch_report());
      clear_batch();
    end
  endfunction

  // Mismatch reporting.
  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Compares one accepted report beat with the oldest pending report.
  task automatic check_report();
    report_t want;
    if (pending_reports.size() == 0) begin
      note_mismatch("report beat with no report pending");
    end else begin
      want = pending_reports.pop_front();
      check_field("report_kind", out_if.report_kind, want.report_kind);
      check_field("segment_number", out_if.segment_number, want.segment_number);
      check_field("sample_count", out_if.sample_count, want.sample_count);
      check_field("segment_empty", out_if.segment_empty, want.segment_empty);
      check_field("mean_q8", out_if.mean_q8, want.mean_q8);
      check_field("segment_min", out_if.segment_min, want.segment_min);
      check_field("batch_empty", out_if.batch_empty, want.batch_empty);
      check_field("max_value", out_if.max_value, want.max_value);
      check_field("max_segment", out_if.max_segment, want.max_segment);
      check_field("max_position", out_if.max_position, want.max_position);
      check_field("last", out_if.last, want.last);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_report();
    end
  end

  // Report channel ready: short random stalls, or one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        out_if.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  // Sends one sample beat and waits for it to be taken.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    track_sample(s);
    samples_sent++;
    if (source_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Stops offering samples and waits until every pending report has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Positive data values, biased toward ties at both ends of the range.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = VALUE_BITS'($urandom_range(1, 8));
      1:       v = VALUE_BITS'($urandom_range(32760, 32767));
      default: v = VALUE_BITS'($urandom_range(1, 32767));
    endcase
    return {1'b0, v};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_batch_end();
    logic [VALUE_BITS-1:0] v;
    v = VALUE_BITS'($urandom());
    return {1'b1, v};
  endfunction

  // A batch of random segments; now and then it ends with a segment still open.
  task automatic send_random_batch(input int max_segments);
    int seg_total;
    int beat_total;
    seg_total = $urandom_range(0, max_segments);
    repeat (seg_total) begin
      beat_total = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      repeat (beat_total) send_sample(pick_value());
      send_sample('0);
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) send_sample(pick_value());
    send_sample(pick_batch_end());
  endtask

  // Field extremes, empty segment and batch, ties for the maximum, both batch-end extremes.
  task automatic test_directed();
    logic signed [SAMPLE_BITS-1:0] beats[$] = '{
      16'shFFFF, 16'sh0000,
      16'sh7FFF, 16'sh0001, 16'sh7FFF, 16'sh0000,
      16'sh0005, 16'sh0005, 16'sh0003, 16'sh0000,
      16'sh0064, 16'sh8000,
      16'sh0001, 16'shAAAA,
      16'sh0000, 16'sh0000, 16'sh0002, 16'sh5555, 16'shFFFE
    };
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    foreach (beats[i]) send_sample(beats[i]);
    wait_drained();
  endtask

  // Random batches with idling switched on and off from batch to batch.
  task automatic test_random_traffic();
    int unsigned first;
    first = samples_sent;
    while (samples_sent < first + 1000) begin
      source_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps   = ($urandom_range(0, 3) != 0);
      send_random_batch(6);
    end
    wait_drained();
  endtask

  // The report side holds off while samples keep coming, so the input stalls.
  task automatic test_backpressure();
    source_gaps  = 1'b0;
    sink_gaps    = 1'b0;
    hold_request = 1'b1;
    repeat (4) begin
      repeat (4) send_sample(pick_value());
      send_sample('0);
    end
    send_sample(pick_batch_end());
    wait_drained();
  endtask

  // Closing traffic without idling on either side.
  task automatic test_quiet_tail();
    int unsigned first;
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    first       = samples_sent;
    while (samples_sent < first + 200) send_random_batch(5);
    wait_drained();
  endtask

  // Reset, then the tests in turn.
  initial begin
    mismatches   = 0;
    samples_sent = 0;
    source_gaps  = 1'b0;
    sink_gaps    = 1'b0;
    hold_request = 1'b0;
    clear_batch();
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic();
    test_backpressure();
    test_quiet_tail();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(64'd2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
